### sv/two_level_tile_reorder_address_gen_assert.svh
// Assertion macros for the two-level tile reorder address generator.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef TWO_LEVEL_TILE_REORDER_ADDRESS_GEN_ASSERT_SVH
`define TWO_LEVEL_TILE_REORDER_ADDRESS_GEN_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TLRAG_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLRAG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/tlrag_pkg.sv
// Shared types and constants for the two-level tile reorder address generator.
// No dependencies.
package tlrag_pkg;

	localparam int ROW_WIDTH_W  = 15;  // row_width register
	localparam int BLOCK_CNT_W  = 9;   // block_columns / block_rows registers
	localparam int BLOCK_CTR_W  = 8;   // block_x / block_y counters
	localparam int BLK_LIN_W    = 17;  // block_x + block_y * columns
	localparam int W3_W         = 17;  // 3 * row_width
	localparam int ADDR_W       = 32;
	localparam int CFG_DATA_W   = 15;
	localparam int CFG_INDEX_W  = 2;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST     = 15'd5952;
	localparam logic [BLOCK_CNT_W-1:0] BLOCK_COLUMNS_RST = 9'd31;
	localparam logic [BLOCK_CNT_W-1:0] BLOCK_ROWS_RST    = 9'd20;
	localparam logic [BLOCK_CNT_W-1:0] BLOCK_CNT_MAX     = 9'd256;
	localparam logic [BLOCK_CNT_W-1:0] BLOCK_CNT_MIN     = 9'd1;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_ROW_WIDTH     = 2'd0,
		REG_BLOCK_COLUMNS = 2'd1,
		REG_BLOCK_ROWS    = 2'd2
	} cfg_reg_t;

endpackage

### sv/tlrag_step_if.sv
// Step request channel: valid/ready plus the tick word.
// Depends on nothing but the handshake convention of the block.
interface tlrag_step_if;
	logic valid;
	logic ready;
	logic tick;

	modport source (output valid, output tick, input ready);
	modport sink   (input valid, input tick, output ready);
endinterface

### sv/tlrag_addr_if.sv
// Address pair channel: valid/ready plus raster address, tiled index, frame flag.
// Depends on tlrag_pkg for the address width.
interface tlrag_addr_if;
	import tlrag_pkg::*;

	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] raster_byte_address;
	logic [ADDR_W-1:0] tiled_index;
	logic              frame_last;

	modport source (output valid, output raster_byte_address, output tiled_index,
		output frame_last, input ready);
	modport sink   (input valid, input raster_byte_address, input tiled_index,
		input frame_last, output ready);
endinterface

### sv/two_level_tile_reorder_address_gen.sv
// Top level of the two-level tile reorder address generator.
// Depends on tlrag_pkg, tlrag_step_if, tlrag_addr_if and the assertion header.

// Generates one (raster byte address, tiled index) pair per word taken on
// step_ch, one word per clock sustained unless addr_ch stalls. The pair is
// taken into stage 1, then into the output register, and is offered on addr_ch.
// Six counters (sub-tile x/y, group x/y, block x/y) run innermost first. The
// pair for the current count is always produced, and the counters advance only
// when tick is 1.
// frame_last flags the final pair, after which a tick wraps all counters.
// The per-clock rate is set by the counter update loop, which completes in
// the accept cycle; the multiplications feed the stage 1 and output registers.
// Config writes (row_width, block_columns, block_rows) must only be made
// while no words are in flight; block counts are clamped to 1..256.
module two_level_tile_reorder_address_gen #(
	parameter int TILE_W    = 4,
	parameter int TILE_H    = 4,
	parameter int GROUP_W   = 48,
	parameter int GROUP_H   = 48,
	parameter int BLOCK_PAD = 0
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_wr_en,
	input  logic [tlrag_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [tlrag_pkg::CFG_DATA_W-1:0]   cfg_data,
	tlrag_step_if.sink                         step_ch,
	tlrag_addr_if.source                       addr_ch
);
	import tlrag_pkg::*;

	// Counter widths follow the tile and group geometry.
	localparam int SXW = (TILE_W  > 1) ? $clog2(TILE_W)  : 1;
	localparam int SYW = (TILE_H  > 1) ? $clog2(TILE_H)  : 1;
	localparam int GXW = (GROUP_W > 1) ? $clog2(GROUP_W) : 1;
	localparam int GYW = (GROUP_H > 1) ? $clog2(GROUP_H) : 1;

	// Pixel row / column ranges span 256 blocks at most.
	localparam int ROW_W  = $clog2(256 * GROUP_H * TILE_H);
	localparam int COL_W  = $clog2(256 * GROUP_W * TILE_W);
	localparam int COL3_W = COL_W + 2;
	localparam int LOC_SPAN = GROUP_W * GROUP_H * TILE_W * TILE_H;
	localparam int LOC_W  = (LOC_SPAN > 1) ? $clog2(LOC_SPAN) : 1;
	localparam logic [ADDR_W-1:0] BLOCK_SIZE = ADDR_W'(LOC_SPAN + BLOCK_PAD);

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [W3_W-1:0]        row_bytes_q;   // 3 * row_width, row stride in bytes
	logic [BLOCK_CNT_W-1:0] block_columns_q;
	logic [BLOCK_CNT_W-1:0] block_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_bytes_q     <= W3_W'(ROW_WIDTH_RST) * W3_W'(3);
			block_columns_q <= BLOCK_COLUMNS_RST;
			block_rows_q    <= BLOCK_ROWS_RST;
		end else if (cfg_wr_en) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROW_WIDTH: begin
					row_bytes_q <= W3_W'(cfg_data) * W3_W'(3);
				end
				REG_BLOCK_COLUMNS: block_columns_q <= cfg_data[BLOCK_CNT_W-1:0];
				REG_BLOCK_ROWS:    block_rows_q    <= cfg_data[BLOCK_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp of a block count to 1..256
	function automatic logic [BLOCK_CNT_W-1:0] clamp_cnt(input logic [BLOCK_CNT_W-1:0] v);
		if (v < BLOCK_CNT_MIN)
			return BLOCK_CNT_MIN;
		else if (v > BLOCK_CNT_MAX)
			return BLOCK_CNT_MAX;
		else
			return v;
	endfunction

	logic [BLOCK_CNT_W-1:0] cols, rows;
	assign cols = clamp_cnt(block_columns_q);
	assign rows = clamp_cnt(block_rows_q);

	// ---------------------------------------------------------------
	// Handshake: output register (_s2) fed by stage 1 (_s1)
	// ---------------------------------------------------------------
	logic valid_s1, valid_s2;
	logic adv_s1, adv_s2, accept;

	assign adv_s2        = !valid_s2 || addr_ch.ready;
	assign adv_s1        = !valid_s1 || adv_s2;
	assign step_ch.ready = adv_s1;
	assign accept        = step_ch.valid && adv_s1;

	// ---------------------------------------------------------------
	// Position counters
	// ---------------------------------------------------------------
	logic [SXW-1:0]         sub_x_q;
	logic [SYW-1:0]         sub_y_q;
	logic [GXW-1:0]         group_x_q;
	logic [GYW-1:0]         group_y_q;
	logic [BLOCK_CTR_W-1:0] block_x_q;
	logic [BLOCK_CTR_W-1:0] block_y_q;

	logic sx_last, sy_last, gx_last, gy_last, bx_last, by_last, frame_end;

	// "Last" is at-or-beyond, so counters left past a shrunk limit still wrap.
	assign sx_last = sub_x_q   >= SXW'(TILE_W - 1);
	assign sy_last = sub_y_q   >= SYW'(TILE_H - 1);
	assign gx_last = group_x_q >= GXW'(GROUP_W - 1);
	assign gy_last = group_y_q >= GYW'(GROUP_H - 1);
	assign bx_last = {1'b0, block_x_q} >= (cols - BLOCK_CNT_MIN);
	assign by_last = {1'b0, block_y_q} >= (rows - BLOCK_CNT_MIN);
	assign frame_end = sx_last && sy_last && gx_last && gy_last && bx_last && by_last;

	logic step;
	assign step = accept && step_ch.tick;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_x_q   <= '0;
			sub_y_q   <= '0;
			group_x_q <= '0;
			group_y_q <= '0;
			block_x_q <= '0;
			block_y_q <= '0;
		end else if (step) begin
			sub_x_q <= sx_last ? '0 : sub_x_q + SXW'(1);
			if (sx_last) begin
				sub_y_q <= sy_last ? '0 : sub_y_q + SYW'(1);
			end
			if (sx_last && sy_last) begin
				group_x_q <= gx_last ? '0 : group_x_q + GXW'(1);
			end
			if (sx_last && sy_last && gx_last) begin
				group_y_q <= gy_last ? '0 : group_y_q + GYW'(1);
			end
			if (sx_last && sy_last && gx_last && gy_last) begin
				block_x_q <= bx_last ? '0 : block_x_q + BLOCK_CTR_W'(1);
			end
			if (sx_last && sy_last && gx_last && gy_last && bx_last) begin
				block_y_q <= by_last ? '0 : block_y_q + BLOCK_CTR_W'(1);
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 1: pixel row, 3*pixel column, linear block number, offset
	// inside the block. Only constant multiplies and one 8x9 multiply.
	// ---------------------------------------------------------------
	logic [ROW_W-1:0]     pix_row;
	logic [COL_W-1:0]     pix_col;
	logic [COL3_W-1:0]    pix_col3;
	logic [BLK_LIN_W-1:0] blk_lin;
	logic [LOC_W-1:0]     blk_off;

	assign pix_row = ROW_W'(block_y_q) * ROW_W'(GROUP_H * TILE_H)
		+ ROW_W'(group_y_q) * ROW_W'(TILE_H) + ROW_W'(sub_y_q);
	assign pix_col = COL_W'(block_x_q) * COL_W'(GROUP_W * TILE_W)
		+ COL_W'(group_x_q) * COL_W'(TILE_W) + COL_W'(sub_x_q);
	assign pix_col3 = {1'b0, pix_col, 1'b0} + COL3_W'(pix_col);
	assign blk_lin = BLK_LIN_W'(block_x_q) + BLK_LIN_W'(block_y_q) * BLK_LIN_W'(cols);
	assign blk_off = (LOC_W'(group_y_q) * LOC_W'(GROUP_W) + LOC_W'(group_x_q))
		* LOC_W'(TILE_W * TILE_H)
		+ LOC_W'(sub_y_q) * LOC_W'(TILE_W) + LOC_W'(sub_x_q);

	logic [ROW_W-1:0]     pix_row_s1;
	logic [COL3_W-1:0]    pix_col3_s1;
	logic [BLK_LIN_W-1:0] blk_lin_s1;
	logic [LOC_W-1:0]     blk_off_s1;
	logic                 last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_row_s1  <= pix_row;
			pix_col3_s1 <= pix_col3;
			blk_lin_s1  <= blk_lin;
			blk_off_s1  <= blk_off;
			last_s1     <= frame_end;
		end
	end

	// ---------------------------------------------------------------
	// Stage 2 (output register): one multiply per address, mod 2^32
	// ---------------------------------------------------------------
	logic [ADDR_W-1:0] raster_s2, tiled_s2;
	logic              last_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			raster_s2 <= ADDR_W'(pix_row_s1) * ADDR_W'(row_bytes_q) + ADDR_W'(pix_col3_s1);
			tiled_s2  <= ADDR_W'(blk_lin_s1) * BLOCK_SIZE + ADDR_W'(blk_off_s1);
			last_s2   <= last_s1;
		end
	end

	assign addr_ch.valid               = valid_s2;
	assign addr_ch.raster_byte_address = raster_s2;
	assign addr_ch.tiled_index         = tiled_s2;
	assign addr_ch.frame_last          = last_s2;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	`include "two_level_tile_reorder_address_gen_assert.svh"

	`TLRAG_ASSERT_NEXT(a_frame_wrap, step && frame_end, (sub_x_q == '0) && (sub_y_q == '0) && (group_x_q == '0) && (group_y_q == '0) && (block_x_q == '0) && (block_y_q == '0), "counters did not wrap after the last pair")
	`TLRAG_ASSERT_NEXT(a_hold_count, !step, $stable(sub_x_q) && $stable(sub_y_q) && $stable(group_x_q) && $stable(group_y_q) && $stable(block_x_q) && $stable(block_y_q), "counters moved without a tick")
	`TLRAG_ASSERT_NEXT(a_s1_kept, valid_s1 && !adv_s2, valid_s1 && $stable(blk_lin_s1) && $stable(last_s1), "stage 1 word lost while output stalled")
	`TLRAG_ASSERT_NOW(a_ready_empty, !valid_s1 || !valid_s2, step_ch.ready, "input not ready with pipeline space free")

endmodule
